// File: rtl/core/msdp_pkg.sv
`timescale 1ns / 1ps

package msdp_pkg;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_DIV,
        ST_FIN
    } state_t;

    // register indexes on the config port
    localparam int CFG_ADDR_W = 1;
    localparam logic [CFG_ADDR_W-1:0] REG_RATE_CONSTANT = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_MIN_PERIOD    = 1'b1;

    localparam int RATE_W = 24;
    localparam int MINP_W = 16;
    localparam int PER_W  = 16;
    localparam int AXIS_W = 2;
    localparam int TGT_W  = 16;
    localparam int OPOS_W = 16;

    localparam logic [RATE_W-1:0] RATE_RESET  = 24'd100000;
    localparam logic [MINP_W-1:0] MINP_RESET  = 16'd100;
    localparam logic [PER_W-1:0]  IDLE_PERIOD = 16'd999;
    localparam logic [PER_W-1:0]  PERIOD_MAX  = 16'hFFFF;

    // one quotient bit per divider cycle
    localparam int DIV_STEPS = RATE_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    // per-request result of the axis state update
    typedef struct packed {
        logic              hit;   // valid axis, not at target: period needs a divide
        logic              dir;
        logic              step;
        logic [OPOS_W-1:0] pos;
    } axis_info_t;

endpackage

// File: rtl/core/msdp_div.sv
`timescale 1ns / 1ps

module msdp_div #(
    parameter int DIVISOR_W = 17
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [msdp_pkg::RATE_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]        divisor,
    output logic                        busy,
    output logic                        done,
    output logic [msdp_pkg::RATE_W-1:0] quotient
);
    import msdp_pkg::*;

    // remainder stays below min(divisor, 2^RATE_W); one more bit for the trial shift
    localparam int REM_W = ((DIVISOR_W > RATE_W) ? DIVISOR_W : RATE_W) + 1;

    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [RATE_W-1:0] quo_reg, quo_next;
    logic [REM_W-1:0]  dvs_reg, dvs_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic [REM_W-1:0]  trial;
    logic              fits;

    assign trial = {rem_reg[REM_W-2:0], quo_reg[RATE_W-1]};
    assign fits  = (trial >= dvs_reg);

    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start) begin
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = REM_W'(divisor);
            cnt_next  = CNT_W'(DIV_STEPS - 1);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = fits ? (trial - dvs_reg) : trial;
            quo_next = {quo_reg[RATE_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign busy     = busy_reg;
    assign done     = busy_reg && (cnt_reg == '0);
    assign quotient = quo_reg;

endmodule

// File: rtl/core/msdp_axes.sv
`timescale 1ns / 1ps

module msdp_axes #(
    parameter int AXES     = 3,
    parameter int POS_BITS = 16,
    parameter int DIST_W   = 17
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic [msdp_pkg::AXIS_W-1:0] sel_axis,
    input  logic signed [msdp_pkg::TGT_W-1:0] target,
    input  logic                        commit,
    output msdp_pkg::axis_info_t        info,
    output logic [DIST_W-1:0]           dist_mag
);
    import msdp_pkg::*;

    localparam int IDX_W = (AXES > 1) ? $clog2(AXES) : 1;
    localparam int PL    = (POS_BITS < OPOS_W) ? POS_BITS : OPOS_W;

    logic [POS_BITS-1:0] pos_reg [AXES];
    logic [AXES-1:0]     dir_reg;
    logic [AXES-1:0]     phase_reg;

    logic [IDX_W-1:0]         idx;
    logic                     valid;
    logic [POS_BITS-1:0]      now;
    logic signed [DIST_W-1:0] now_x, set_x, diff;
    logic                     at_target, req;
    logic                     dir_n, phase_n;
    logic [POS_BITS-1:0]      pos_n;

    assign idx   = IDX_W'(sel_axis);
    assign valid = (32'(sel_axis) < AXES);

    always_comb begin
        now       = valid ? pos_reg[idx] : '0;
        now_x     = DIST_W'(signed'(now));
        set_x     = DIST_W'(target);
        diff      = set_x - now_x;
        at_target = (diff == '0);
        req       = diff[DIST_W-1];          // negative distance: count down
        dist_mag  = diff[DIST_W-1] ? DIST_W'(-diff) : DIST_W'(diff);

        dir_n   = valid ? dir_reg[idx] : 1'b0;
        phase_n = valid ? phase_reg[idx] : 1'b0;
        pos_n   = now;
        if (valid && !at_target) begin
            if (!phase_n) begin
                if (dir_n != req) begin
                    dir_n = req;
                end else begin
                    phase_n = 1'b1;
                end
            end else begin
                phase_n = 1'b0;
                pos_n   = dir_n ? (now - 1'b1) : (now + 1'b1);
            end
        end

        info          = '0;
        info.hit      = valid && !at_target;
        info.dir      = dir_n;
        info.step     = !phase_n;
        info.pos[PL-1:0] = pos_n[PL-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < AXES; i++) begin
                pos_reg[i] <= '0;
            end
            dir_reg   <= '0;
            phase_reg <= '0;
        end else if (commit && valid) begin
            pos_reg[idx]   <= pos_n;
            dir_reg[idx]   <= dir_n;
            phase_reg[idx] <= phase_n;
        end
    end

endmodule

// File: rtl/core/multi_axis_step_dir_pulser.sv
`timescale 1ns / 1ps
// Path: a request at target or for a bad axis goes from accept through ST_CALC
//   and ST_FIN to m_tvalid; a computed period adds the radix-2 serial divider (ST_DIV).
// Flow: one request at a time, and ST_FIN waits while a result is held; the next
//   request is taken while the previous result still waits in the output register.
// Reset: synchronous, active low; positions, directions and pulse phases clear,
//   rate_constant = 100000, min_period = 100, no result pending.
module multi_axis_step_dir_pulser #(
    parameter int AXES     = 3,
    parameter int POS_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    // config write port
    input  logic                            cfg_we,
    input  logic [msdp_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [msdp_pkg::RATE_W-1:0]     cfg_wdata,
    // tick requests
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] target
    input  logic [1:0]  s_tuser,   // [1:0] axis
    // results
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [0] dir_level, [1] step_level, [17:2] next_period,
                                   // [33:18] position, [39:34] zero
    output logic [1:0]  m_tuser    // [1:0] axis_out
);
    import msdp_pkg::*;

    // signed distance needs one bit over the wider of position and target
    localparam int DIST_W = ((POS_BITS > TGT_W) ? POS_BITS : TGT_W) + 1;

    state_t state_reg, state_next;

    logic [RATE_W-1:0] rate_reg;
    logic [MINP_W-1:0] minp_reg;

    logic [AXIS_W-1:0] axis_reg, axis_next;
    logic [TGT_W-1:0]  target_reg, target_next;
    axis_info_t        info_reg, info_next;

    logic              m_tvalid_reg, m_tvalid_next;
    logic [39:0]       m_tdata_reg, m_tdata_next;
    logic [1:0]        m_tuser_reg, m_tuser_next;

    axis_info_t        info;
    logic [DIST_W-1:0] dist_mag;
    logic              commit;
    logic              div_start, div_busy, div_done;
    logic [RATE_W-1:0] quotient;
    logic [MINP_W-1:0] min_eff;
    logic [PER_W-1:0]  period;

    // per-axis position / direction / phase storage and the step decision
    msdp_axes #(
        .AXES     (AXES),
        .POS_BITS (POS_BITS),
        .DIST_W   (DIST_W)
    ) u_axes (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .sel_axis (axis_reg),
        .target   (signed'(target_reg)),
        .commit   (commit),
        .info     (info),
        .dist_mag (dist_mag)
    );

    // rate_constant / distance, one quotient bit per cycle
    msdp_div #(
        .DIVISOR_W (DIST_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (rate_reg),
        .divisor  (dist_mag),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (quotient)
    );

    // zero min_period behaves as 1; clamp below by it, saturate at 16 bits; no divide gives IDLE_PERIOD
    always_comb begin
        min_eff = (minp_reg == '0) ? MINP_W'(1) : minp_reg;
        if (!info_reg.hit) begin
            period = IDLE_PERIOD;
        end else if (quotient < RATE_W'(min_eff)) begin
            period = min_eff;
        end else if (quotient > RATE_W'(PERIOD_MAX)) begin
            period = PERIOD_MAX;
        end else begin
            period = quotient[PER_W-1:0];
        end
    end

    always_comb begin
        state_next    = state_reg;
        axis_next     = axis_reg;
        target_next   = target_reg;
        info_next     = info_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        s_tready      = 1'b0;
        commit        = 1'b0;
        div_start     = 1'b0;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    axis_next   = s_tuser;
                    target_next = s_tdata;
                    state_next  = ST_CALC;
                end
            end
            ST_CALC: begin
                // state update lands now; the period follows from the old position
                commit    = 1'b1;
                info_next = info;
                if (info.hit) begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end else begin
                    state_next = ST_FIN;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = axis_reg;
                    m_tdata_next  = {6'd0, info_reg.pos, period, info_reg.step, info_reg.dir};
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            rate_reg     <= RATE_RESET;
            minp_reg     <= MINP_RESET;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_we) begin
                case (cfg_addr)
                    REG_RATE_CONSTANT: rate_reg <= cfg_wdata;
                    REG_MIN_PERIOD:    minp_reg <= cfg_wdata[MINP_W-1:0];
                    default: ;
                endcase
            end
        end
        axis_reg    <= axis_next;
        target_reg  <= target_next;
        info_reg    <= info_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // an accepted request always goes to the state update next
    a_accept_to_calc: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == ST_CALC))
        else $error("accepted request did not enter update state");

    // divider must be running whenever the controller waits on it
    a_div_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> div_busy)
        else $error("waiting on an idle divider");

    // a delivered period is never zero
    a_period_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[17:2] != 16'd0))
        else $error("zero tick period");

endmodule
